>>> rtl/uhid_pkg.sv
package uhid_pkg;

    localparam int PACKET_BYTES = 32;
    localparam int FRAME_DIVIDE = 4;
    localparam int FRAME_W      = (FRAME_DIVIDE > 1) ? $clog2(FRAME_DIVIDE) : 1;

    localparam logic [1:0] OP_SETUP = 2'd0;
    localparam logic [1:0] OP_SOF   = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;
    localparam logic [1:0] OP_SEND  = 2'd3;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_STALL   = 3'd1;
    localparam logic [2:0] ACT_ACK     = 3'd2;
    localparam logic [2:0] ACT_DATA    = 3'd3;
    localparam logic [2:0] ACT_REPORT  = 3'd4;
    localparam logic [2:0] ACT_REFUSED = 3'd5;

    localparam logic [2:0] SRC_INLINE = 3'd0;
    localparam logic [2:0] SRC_DEVICE = 3'd1;
    localparam logic [2:0] SRC_CONFIG = 3'd2;
    localparam logic [2:0] SRC_HID    = 3'd3;
    localparam logic [2:0] SRC_REPORT = 3'd4;

    localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;

    localparam logic [7:0] HID_GET_REPORT   = 8'h01;
    localparam logic [7:0] HID_GET_IDLE     = 8'h02;
    localparam logic [7:0] HID_GET_PROTOCOL = 8'h03;
    localparam logic [7:0] HID_SET_IDLE     = 8'h0A;
    localparam logic [7:0] HID_SET_PROTOCOL = 8'h0B;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_HID    = 8'h21;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam logic [7:0] RT_STD_OUT   = 8'h00;
    localparam logic [7:0] RT_STD_IN    = 8'h80;
    localparam logic [7:0] RT_CLASS_IN  = 8'hA1;
    localparam logic [7:0] RT_CLASS_OUT = 8'h21;

    localparam logic [1:0] LINK_UNKNOWN      = 2'd0;
    localparam logic [1:0] LINK_DISCONNECTED = 2'd1;
    localparam logic [1:0] LINK_ATTACHED     = 2'd2;

    localparam logic [1:0] CFG_DEVICE_LEN = 2'd0;
    localparam logic [1:0] CFG_BUNDLE_LEN = 2'd1;
    localparam logic [1:0] CFG_HID_LEN    = 2'd2;
    localparam logic [1:0] CFG_REPORT_LEN = 2'd3;

    typedef struct packed {
        logic capture;
        logic decode;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic have_item;
        logic item_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/uhid_ctrl.sv
module uhid_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  uhid_pkg::dp_status_t status,
    output uhid_pkg::dp_cmd_t    cmd
);
    import uhid_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.decode  = 1'b0;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.have_item) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.item_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/uhid_dp.sv
module uhid_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uhid_pkg::dp_cmd_t    cmd,
    output uhid_pkg::dp_status_t status,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [9:0]           cfg_wdata,
    input  logic [1:0]           s_opcode,
    input  logic [7:0]           s_request_type,
    input  logic [7:0]           s_request_code,
    input  logic [15:0]          s_request_value,
    input  logic [15:0]          s_request_index,
    input  logic [15:0]          s_transfer_length,
    input  logic [47:0]          s_key_codes,
    input  logic                 s_endpoint_writable,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_action,
    output logic [2:0]           m_source,
    output logic [7:0]           m_byte_offset,
    output logic [5:0]           m_byte_count,
    output logic [63:0]          m_inline_data,
    output logic                 m_last
);
    import uhid_pkg::*;

    // configuration
    logic [7:0] dev_len_reg;
    logic [9:0] bundle_len_reg;
    logic [7:0] hid_len_reg;
    logic [7:0] rpt_len_reg;

    // captured request
    logic [1:0]  op_reg;
    logic [7:0]  rtype_reg;
    logic [7:0]  code_reg;
    logic [15:0] value_reg;
    logic [15:0] index_reg;
    logic [15:0] wlen_reg;
    logic [47:0] keys_reg;
    logic        writable_reg;

    // device state
    logic [1:0]         link_reg, link_next;
    logic [6:0]         addr_reg, addr_next;
    logic               addr_en_reg, addr_en_next;
    logic [15:0]        idle_rate_reg, idle_rate_next;
    logic [7:0]         idle_cnt_reg, idle_cnt_next;
    logic [FRAME_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [7:0]         protocol_reg, protocol_next;

    // result sequencer
    logic        single_reg, single_next;
    logic [2:0]  s_act_reg, s_act_next;
    logic [5:0]  s_cnt_reg, s_cnt_next;
    logic [63:0] s_data_reg, s_data_next;
    logic [2:0]  src_reg, src_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  off_reg, off_next;
    logic        zlp_reg, zlp_next;

    // output register
    logic        m_valid_reg;
    logic [2:0]  m_action_reg;
    logic [2:0]  m_source_reg;
    logic [7:0]  m_offset_reg;
    logic [5:0]  m_count_reg;
    logic [63:0] m_data_reg;
    logic        m_last_reg;

    logic [63:0] report;
    logic [7:0]  req_len;
    logic [9:0]  avail;
    logic [7:0]  total;
    logic [7:0]  pkt_size;
    logic [7:0]  idle_inc;
    logic        is_desc;
    logic        is_bundle;

    logic [2:0]  g_act;
    logic [2:0]  g_src;
    logic [7:0]  g_off;
    logic [5:0]  g_cnt;
    logic [63:0] g_data;
    logic        g_last;

    assign report = {keys_reg, 16'h0000};

    assign m_valid       = m_valid_reg;
    assign m_action      = m_action_reg;
    assign m_source      = m_source_reg;
    assign m_byte_offset = m_offset_reg;
    assign m_byte_count  = m_count_reg;
    assign m_inline_data = m_data_reg;
    assign m_last        = m_last_reg;

    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.have_item = single_reg || (rem_reg != 8'd0) || zlp_reg;
    assign status.item_last = g_last;

    // descriptor length clamp
    always_comb begin
        req_len   = (|wlen_reg[15:8]) ? 8'hFF : wlen_reg[7:0];
        is_desc   = 1'b1;
        is_bundle = 1'b0;
        avail     = 10'd0;
        src_next  = SRC_INLINE;
        case (value_reg[15:8])
            DT_DEVICE: begin
                avail    = {2'b00, dev_len_reg};
                src_next = SRC_DEVICE;
            end
            DT_CONFIG: begin
                avail     = bundle_len_reg;
                src_next  = SRC_CONFIG;
                is_bundle = 1'b1;
            end
            DT_HID: begin
                avail    = {2'b00, hid_len_reg};
                src_next = SRC_HID;
            end
            DT_REPORT: begin
                avail    = {2'b00, rpt_len_reg};
                src_next = SRC_REPORT;
            end
            default: begin
                is_desc = 1'b0;
            end
        endcase
        total = (avail > {2'b00, req_len}) ? req_len : avail[7:0];
    end

    // next result out of the sequencer
    always_comb begin
        pkt_size = (rem_reg > 8'(PACKET_BYTES)) ? 8'(PACKET_BYTES) : rem_reg;
        g_src    = SRC_INLINE;
        g_off    = 8'd0;
        g_data   = 64'd0;
        g_act    = ACT_DATA;
        g_cnt    = 6'd0;
        g_last   = 1'b1;
        if (single_reg) begin
            g_act  = s_act_reg;
            g_cnt  = s_cnt_reg;
            g_data = s_data_reg;
        end else if (rem_reg != 8'd0) begin
            g_src  = src_reg;
            g_off  = off_reg;
            g_cnt  = pkt_size[5:0];
            g_last = (rem_reg == pkt_size) && !zlp_reg;
        end else begin
            g_src = src_reg;
            g_off = off_reg;
        end
    end

    // request decode and sequencer update
    always_comb begin
        link_next      = link_reg;
        addr_next      = addr_reg;
        addr_en_next   = addr_en_reg;
        idle_rate_next = idle_rate_reg;
        idle_cnt_next  = idle_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        protocol_next  = protocol_reg;
        single_next    = single_reg;
        s_act_next     = s_act_reg;
        s_cnt_next     = s_cnt_reg;
        s_data_next    = s_data_reg;
        rem_next       = rem_reg;
        off_next       = off_reg;
        zlp_next       = zlp_reg;
        idle_inc       = idle_cnt_reg + 8'd1;

        if (cmd.decode) begin
            single_next = 1'b0;
            s_act_next  = ACT_NONE;
            s_cnt_next  = 6'd0;
            s_data_next = 64'd0;
            rem_next    = 8'd0;
            off_next    = 8'd0;
            zlp_next    = 1'b0;
            case (op_reg)
                OP_SETUP: begin
                    case (code_reg)
                        REQ_GET_DESCRIPTOR: begin
                            if (is_desc) begin
                                rem_next = total;
                                zlp_next = is_bundle && ((total % PACKET_BYTES) == 0);
                            end else begin
                                single_next = 1'b1;
                                s_act_next  = ACT_STALL;
                            end
                        end
                        REQ_SET_CONFIG: begin
                            if (rtype_reg == RT_STD_OUT) begin
                                link_next   = LINK_ATTACHED;
                                single_next = 1'b1;
                                s_act_next  = ACT_ACK;
                            end
                        end
                        REQ_SET_ADDRESS: begin
                            addr_next    = value_reg[6:0];
                            addr_en_next = 1'b1;
                            single_next  = 1'b1;
                            s_act_next   = ACT_ACK;
                        end
                        REQ_GET_CONFIG: begin
                            if (rtype_reg == RT_STD_IN) begin
                                single_next = 1'b1;
                                s_act_next  = ACT_DATA;
                                s_cnt_next  = 6'd1;
                                s_data_next = {63'd0, link_reg == LINK_ATTACHED};
                            end
                        end
                        REQ_GET_STATUS: begin
                            single_next = 1'b1;
                            s_act_next  = ACT_DATA;
                            s_cnt_next  = 6'd2;
                        end
                        default: begin
                            single_next = 1'b1;
                            s_act_next  = ACT_STALL;
                            if (index_reg == 16'd0) begin
                                if (rtype_reg == RT_CLASS_IN) begin
                                    case (code_reg)
                                        HID_GET_REPORT: begin
                                            s_act_next  = ACT_DATA;
                                            s_cnt_next  = 6'd8;
                                            s_data_next = report;
                                        end
                                        HID_GET_IDLE: begin
                                            s_act_next  = ACT_DATA;
                                            s_cnt_next  = 6'd1;
                                            s_data_next = {56'd0, idle_rate_reg[7:0]};
                                        end
                                        HID_GET_PROTOCOL: begin
                                            s_act_next  = ACT_DATA;
                                            s_cnt_next  = 6'd1;
                                            s_data_next = {56'd0, protocol_reg};
                                        end
                                        default: begin
                                            s_act_next = ACT_STALL;
                                        end
                                    endcase
                                end else if (rtype_reg == RT_CLASS_OUT) begin
                                    case (code_reg)
                                        HID_SET_IDLE: begin
                                            idle_rate_next = value_reg;
                                            idle_cnt_next  = 8'd0;
                                            s_act_next     = ACT_ACK;
                                        end
                                        HID_SET_PROTOCOL: begin
                                            protocol_next = value_reg[15:8];
                                            s_act_next    = ACT_ACK;
                                        end
                                        default: begin
                                            s_act_next = ACT_STALL;
                                        end
                                    endcase
                                end
                            end
                        end
                    endcase
                end
                OP_SOF: begin
                    if (link_reg == LINK_ATTACHED) begin
                        if (frame_cnt_reg == FRAME_W'(FRAME_DIVIDE - 1)) begin
                            frame_cnt_next = '0;
                        end else begin
                            frame_cnt_next = frame_cnt_reg + FRAME_W'(1);
                        end
                        if ((idle_rate_reg != 16'd0) && (frame_cnt_next == '0)
                            && writable_reg) begin
                            idle_cnt_next = idle_inc;
                            if ({8'd0, idle_inc} == idle_rate_reg) begin
                                idle_cnt_next = 8'd0;
                                single_next   = 1'b1;
                                s_act_next    = ACT_REPORT;
                                s_cnt_next    = 6'd8;
                                s_data_next   = report;
                            end
                        end
                    end
                end
                OP_RESET: begin
                    link_next = LINK_DISCONNECTED;
                end
                OP_SEND: begin
                    single_next = 1'b1;
                    if ((link_reg != LINK_ATTACHED) || !writable_reg) begin
                        s_act_next = ACT_REFUSED;
                    end else begin
                        idle_cnt_next = 8'd0;
                        s_act_next    = ACT_REPORT;
                        s_cnt_next    = 6'd8;
                        s_data_next   = report;
                    end
                end
                default: begin
                    single_next = 1'b0;
                end
            endcase
        end else if (cmd.emit) begin
            if (single_reg) begin
                single_next = 1'b0;
            end else if (rem_reg != 8'd0) begin
                rem_next = rem_reg - pkt_size;
                off_next = off_reg + pkt_size;
            end else begin
                zlp_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= s_opcode;
            rtype_reg    <= s_request_type;
            code_reg     <= s_request_code;
            value_reg    <= s_request_value;
            index_reg    <= s_request_index;
            wlen_reg     <= s_transfer_length;
            keys_reg     <= s_key_codes;
            writable_reg <= s_endpoint_writable;
        end
        s_act_reg  <= s_act_next;
        s_cnt_reg  <= s_cnt_next;
        s_data_reg <= s_data_next;
        src_reg    <= cmd.decode ? src_next : src_reg;
        off_reg    <= off_next;
        if (cmd.emit) begin
            m_action_reg <= g_act;
            m_source_reg <= g_src;
            m_offset_reg <= g_off;
            m_count_reg  <= g_cnt;
            m_data_reg   <= g_data;
            m_last_reg   <= g_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_len_reg    <= 8'd18;
            bundle_len_reg <= 10'd34;
            hid_len_reg    <= 8'd9;
            rpt_len_reg    <= 8'd63;
            link_reg       <= LINK_UNKNOWN;
            addr_reg       <= 7'd0;
            addr_en_reg    <= 1'b0;
            idle_rate_reg  <= 16'd125;
            idle_cnt_reg   <= 8'd0;
            frame_cnt_reg  <= '0;
            protocol_reg   <= 8'd0;
            single_reg     <= 1'b0;
            rem_reg        <= 8'd0;
            zlp_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DEVICE_LEN: dev_len_reg    <= cfg_wdata[7:0];
                    CFG_BUNDLE_LEN: bundle_len_reg <= cfg_wdata;
                    CFG_HID_LEN:    hid_len_reg    <= cfg_wdata[7:0];
                    CFG_REPORT_LEN: rpt_len_reg    <= cfg_wdata[7:0];
                    default: begin
                        dev_len_reg <= dev_len_reg;
                    end
                endcase
            end
            link_reg      <= link_next;
            addr_reg      <= addr_next;
            addr_en_reg   <= addr_en_next;
            idle_rate_reg <= idle_rate_next;
            idle_cnt_reg  <= idle_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            protocol_reg  <= protocol_next;
            single_reg    <= single_next;
            rem_reg       <= rem_next;
            zlp_reg       <= zlp_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/usb_hid_control_request_handler.sv
// Flow: a transfer is captured, then decoded, and its first result is registered on the output
// in the emit state; a transfer gives up to 8 results, one descriptor packet per cycle while
// m_ready stays high, and a new transfer is taken only once the decode/emit sequencer is idle.
// Reset: synchronous active-low aresetn restores register defaults and clears
// device state, the sequencer and the output valid.
module usb_hid_control_request_handler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_request_type,
    input  logic [7:0]  s_request_code,
    input  logic [15:0] s_request_value,
    input  logic [15:0] s_request_index,
    input  logic [15:0] s_transfer_length,
    input  logic [47:0] s_key_codes,
    input  logic        s_endpoint_writable,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [2:0]  m_source,
    output logic [7:0]  m_byte_offset,
    output logic [5:0]  m_byte_count,
    output logic [63:0] m_inline_data,
    output logic        m_last
);
    import uhid_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    uhid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    uhid_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_opcode            (s_opcode),
        .s_request_type      (s_request_type),
        .s_request_code      (s_request_code),
        .s_request_value     (s_request_value),
        .s_request_index     (s_request_index),
        .s_transfer_length   (s_transfer_length),
        .s_key_codes         (s_key_codes),
        .s_endpoint_writable (s_endpoint_writable),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_action            (m_action),
        .m_source            (m_source),
        .m_byte_offset       (m_byte_offset),
        .m_byte_count        (m_byte_count),
        .m_inline_data       (m_inline_data),
        .m_last              (m_last)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import uhid_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 5;
    localparam int MAX_RESULTS     = 9;
    localparam int LENGTH_CAP      = 255;
    localparam int MAX_GAP         = 12;
    localparam int NUM_DIRECTED    = 30;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_PRINTED     = 40;

    localparam logic [7:0] DT_UNKNOWN  = 8'h03;
    localparam logic [7:0] REQ_UNKNOWN = 8'hFF;
    localparam logic [7:0] RT_ANY      = 8'hFF;

    localparam logic [1:0] FROM_MODEL = 2'd0;
    localparam logic [1:0] NO_RESULT  = 2'd1;
    localparam logic [1:0] ONE_RESULT = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] wlen;
        logic [47:0] keys;
        logic        writable;
    } setup_xfer_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  source;
        logic [7:0]  offset;
        logic [5:0]  count;
        logic [63:0] data;
        logic        last;
    } response_t;

    typedef struct packed {
        setup_xfer_t xfer;
        logic [1:0]  kind;
        logic [2:0]  action;
        logic [5:0]  count;
        logic [63:0] data;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_DEVICE_LEN;
    logic [9:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_SETUP;
    logic [7:0]  s_request_type = '0;
    logic [7:0]  s_request_code = '0;
    logic [15:0] s_request_value = '0;
    logic [15:0] s_request_index = '0;
    logic [15:0] s_transfer_length = '0;
    logic [47:0] s_key_codes = '0;
    logic        s_endpoint_writable = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_action;
    logic [2:0]  m_source;
    logic [7:0]  m_byte_offset;
    logic [5:0]  m_byte_count;
    logic [63:0] m_inline_data;
    logic        m_last;

    usb_hid_control_request_handler u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_request_type      (s_request_type),
        .s_request_code      (s_request_code),
        .s_request_value     (s_request_value),
        .s_request_index     (s_request_index),
        .s_transfer_length   (s_transfer_length),
        .s_key_codes         (s_key_codes),
        .s_endpoint_writable (s_endpoint_writable),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_action            (m_action),
        .m_source            (m_source),
        .m_byte_offset       (m_byte_offset),
        .m_byte_count        (m_byte_count),
        .m_inline_data       (m_inline_data),
        .m_last              (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // device model state
    logic [7:0]         device_len;
    logic [9:0]         bundle_len;
    logic [7:0]         hid_len;
    logic [7:0]         report_len;
    logic [1:0]         link_state;
    logic [6:0]         dev_address;
    logic               address_on;
    logic [15:0]        idle_rate;
    logic [7:0]         idle_count;
    logic [FRAME_W-1:0] frame_count;
    logic [7:0]         protocol_mode;

    response_t awaited_responses[$];
    response_t step_responses[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        burst_mode = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic reset_model();
        device_len = 8'd18;
        bundle_len = 10'd34;
        hid_len = 8'd9;
        report_len = 8'd63;
        link_state = LINK_UNKNOWN;
        dev_address = '0;
        address_on = 1'b0;
        idle_rate = 16'd125;
        idle_count = '0;
        frame_count = '0;
        protocol_mode = '0;
    endtask

    function automatic void emit_response(input logic [2:0] action, input logic [2:0] source,
                                          input logic [7:0] offset, input logic [5:0] count,
                                          input logic [63:0] data);
        if (step_responses.size() < MAX_RESULTS) begin
            step_responses.push_back('{action, source, offset, count, data, 1'b0});
        end
    endfunction

    function automatic void descriptor_packets(input logic [2:0] source, input int avail,
                                               input int wlen, input bit bundle);
        int total;
        int offs;
        int rem;
        int sz;
        total = (wlen > LENGTH_CAP) ? LENGTH_CAP : wlen;
        if (avail < total) total = avail;
        offs = 0;
        rem = total;
        while (rem > 0 && step_responses.size() < MAX_RESULTS) begin
            sz = (rem > PACKET_BYTES) ? PACKET_BYTES : rem;
            emit_response(ACT_DATA, source, 8'(offs), 6'(sz), '0);
            offs += sz;
            rem -= sz;
        end
        // bundle ends on a short packet, zero-length if it fills packets exactly
        if (bundle && total % PACKET_BYTES == 0) begin
            emit_response(ACT_DATA, source, 8'(total), 6'd0, '0);
        end
    endfunction

    function automatic void class_request(input setup_xfer_t x);
        bit handled;
        handled = 1'b0;
        if (x.index != 16'd0) begin
            emit_response(ACT_STALL, SRC_INLINE, 8'd0, 6'd0, '0);
            return;
        end
        if (x.rtype == RT_CLASS_IN) begin
            handled = 1'b1;
            case (x.code)
                HID_GET_REPORT:   emit_response(ACT_DATA, SRC_INLINE, 8'd0, 6'd8,
                                                {x.keys, 16'h0000});
                HID_GET_IDLE:     emit_response(ACT_DATA, SRC_INLINE, 8'd0, 6'd1,
                                                {56'd0, idle_rate[7:0]});
                HID_GET_PROTOCOL: emit_response(ACT_DATA, SRC_INLINE, 8'd0, 6'd1,
                                                {56'd0, protocol_mode});
                default:          handled = 1'b0;
            endcase
        end
        if (x.rtype == RT_CLASS_OUT) begin
            handled = 1'b1;
            case (x.code)
                HID_SET_IDLE: begin
                    idle_rate = x.value;
                    idle_count = '0;
                    emit_response(ACT_ACK, SRC_INLINE, 8'd0, 6'd0, '0);
                end
                HID_SET_PROTOCOL: begin
                    protocol_mode = x.value[15:8];
                    emit_response(ACT_ACK, SRC_INLINE, 8'd0, 6'd0, '0);
                end
                default: handled = 1'b0;
            endcase
        end
        if (!handled) emit_response(ACT_STALL, SRC_INLINE, 8'd0, 6'd0, '0);
    endfunction

    function automatic void setup_request(input setup_xfer_t x);
        case (x.code)
            REQ_GET_DESCRIPTOR: begin
                case (x.value[15:8])
                    DT_DEVICE: descriptor_packets(SRC_DEVICE, int'(device_len), int'(x.wlen), 1'b0);
                    DT_CONFIG: descriptor_packets(SRC_CONFIG, int'(bundle_len), int'(x.wlen), 1'b1);
                    DT_HID:    descriptor_packets(SRC_HID, int'(hid_len), int'(x.wlen), 1'b0);
                    DT_REPORT: descriptor_packets(SRC_REPORT, int'(report_len), int'(x.wlen), 1'b0);
                    default:   emit_response(ACT_STALL, SRC_INLINE, 8'd0, 6'd0, '0);
                endcase
            end
            REQ_SET_CONFIG: begin
                // the class report write shares this code and falls out here
                if (x.rtype == RT_STD_OUT) begin
                    link_state = LINK_ATTACHED;
                    emit_response(ACT_ACK, SRC_INLINE, 8'd0, 6'd0, '0);
                end
            end
            REQ_SET_ADDRESS: begin
                dev_address = x.value[6:0];
                address_on = 1'b1;
                emit_response(ACT_ACK, SRC_INLINE, 8'd0, 6'd0, '0);
            end
            REQ_GET_CONFIG: begin
                if (x.rtype == RT_STD_IN) begin
                    emit_response(ACT_DATA, SRC_INLINE, 8'd0, 6'd1,
                                  {63'd0, link_state == LINK_ATTACHED});
                end
            end
            REQ_GET_STATUS: emit_response(ACT_DATA, SRC_INLINE, 8'd0, 6'd2, '0);
            default:        class_request(x);
        endcase
    endfunction

    function automatic void predict_request(input setup_xfer_t x);
        step_responses.delete();
        case (x.op)
            OP_SETUP: setup_request(x);
            OP_SOF: begin
                if (link_state == LINK_ATTACHED) begin
                    frame_count = (int'(frame_count) == FRAME_DIVIDE - 1) ? '0
                                : FRAME_W'(int'(frame_count) + 1);
                    if (idle_rate != 16'd0 && frame_count == '0 && x.writable) begin
                        idle_count = idle_count + 8'd1;
                        if ({8'd0, idle_count} == idle_rate) begin
                            idle_count = '0;
                            emit_response(ACT_REPORT, SRC_INLINE, 8'd0, 6'd8,
                                          {x.keys, 16'h0000});
                        end
                    end
                end
            end
            OP_RESET: link_state = LINK_DISCONNECTED;
            default: begin
                if (link_state != LINK_ATTACHED || !x.writable) begin
                    emit_response(ACT_REFUSED, SRC_INLINE, 8'd0, 6'd0, '0);
                end else begin
                    idle_count = '0;
                    emit_response(ACT_REPORT, SRC_INLINE, 8'd0, 6'd8, {x.keys, 16'h0000});
                end
            end
        endcase
        if (step_responses.size() > 0) step_responses[step_responses.size() - 1].last = 1'b1;
    endfunction

    function automatic setup_xfer_t random_request();
        setup_xfer_t x;
        int unsigned pick;
        x.op = OP_SETUP;
        x.rtype = 8'($urandom);
        x.code = 8'($urandom);
        x.value = 16'($urandom);
        x.index = 16'($urandom);
        x.wlen = 16'($urandom);
        x.keys = {16'($urandom), 32'($urandom)};
        x.writable = ($urandom_range(0, 7) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            x.op = OP_SOF;
        end else if (pick < 23) begin
            x.op = OP_RESET;
        end else if (pick < 38) begin
            x.op = OP_SEND;
        end else if (pick < 92) begin
            if ($urandom_range(0, 9) != 0) x.index = '0;
            case ($urandom_range(0, 12))
                0, 1, 2, 3: begin
                    x.rtype = RT_STD_IN;
                    x.code = REQ_GET_DESCRIPTOR;
                    case ($urandom_range(0, 8))
                        0, 1:    x.value[15:8] = DT_DEVICE;
                        2, 3:    x.value[15:8] = DT_CONFIG;
                        4, 5:    x.value[15:8] = DT_HID;
                        6, 7:    x.value[15:8] = DT_REPORT;
                        default: ;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       x.wlen = '0;
                        1:       x.wlen = 16'($urandom_range(1, 64));
                        2:       x.wlen = 16'($urandom_range(65, 300));
                        default: ;
                    endcase
                end
                4: begin
                    x.code = REQ_SET_CONFIG;
                    if ($urandom_range(0, 5) != 0) x.rtype = RT_STD_OUT;
                end
                5: begin
                    x.code = REQ_SET_ADDRESS;
                    x.rtype = RT_STD_OUT;
                end
                6: begin
                    x.code = REQ_GET_CONFIG;
                    if ($urandom_range(0, 5) != 0) x.rtype = RT_STD_IN;
                end
                7: begin
                    x.code = REQ_GET_STATUS;
                    x.rtype = RT_STD_IN;
                end
                8: begin
                    x.code = HID_GET_REPORT;
                    x.rtype = RT_CLASS_IN;
                end
                9: begin
                    x.code = HID_GET_IDLE;
                    x.rtype = RT_CLASS_IN;
                end
                10: begin
                    x.code = HID_GET_PROTOCOL;
                    x.rtype = RT_CLASS_IN;
                end
                11: begin
                    x.code = HID_SET_IDLE;
                    x.rtype = RT_CLASS_OUT;
                    case ($urandom_range(0, 5))
                        0:          x.value = '0;
                        1, 2, 3, 4: x.value = 16'($urandom_range(1, 3));
                        default:    ;
                    endcase
                end
                default: begin
                    x.code = HID_SET_PROTOCOL;
                    x.rtype = RT_CLASS_OUT;
                end
            endcase
        end
        return x;
    endfunction

    task automatic send_transfer(input setup_xfer_t x, input logic [1:0] kind,
                                 input response_t typed);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= x.op;
        s_request_type <= x.rtype;
        s_request_code <= x.code;
        s_request_value <= x.value;
        s_request_index <= x.index;
        s_transfer_length <= x.wlen;
        s_key_codes <= x.keys;
        s_endpoint_writable <= x.writable;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(x);
        if (kind == FROM_MODEL) begin
            foreach (step_responses[i]) awaited_responses.push_back(step_responses[i]);
        end else if (kind == ONE_RESULT) begin
            awaited_responses.push_back(typed);
        end
    endtask

    task automatic write_lengths(input logic [9:0] dev, input logic [9:0] bundle,
                                 input logic [9:0] hid, input logic [9:0] rpt);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEVICE_LEN;
        cfg_wdata <= dev;
        @(posedge aclk);
        cfg_index <= CFG_BUNDLE_LEN;
        cfg_wdata <= bundle;
        @(posedge aclk);
        cfg_index <= CFG_HID_LEN;
        cfg_wdata <= hid;
        @(posedge aclk);
        cfg_index <= CFG_REPORT_LEN;
        cfg_wdata <= rpt;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        device_len = dev[7:0];
        bundle_len = bundle;
        hid_len = hid[7:0];
        report_len = rpt[7:0];
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(aresetn && m_valid)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        response_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_responses.size() == 0) begin
                report_mismatch("transfer with nothing pending, action", 64'(m_action), '0);
            end else begin
                want = awaited_responses.pop_front();
                if (m_action !== want.action)
                    report_mismatch("action", 64'(m_action), 64'(want.action));
                if (m_source !== want.source)
                    report_mismatch("source", 64'(m_source), 64'(want.source));
                if (m_byte_offset !== want.offset)
                    report_mismatch("byte_offset", 64'(m_byte_offset), 64'(want.offset));
                if (m_byte_count !== want.count)
                    report_mismatch("byte_count", 64'(m_byte_count), 64'(want.count));
                if (m_inline_data !== want.data)
                    report_mismatch("inline_data", m_inline_data, want.data);
                if (m_last !== want.last)
                    report_mismatch("last", 64'(m_last), 64'(want.last));
            end
        end
    end

    initial begin : stimulus
        directed_row_t directed [NUM_DIRECTED];
        response_t     typed;
        reset_model();
        directed = '{
            '{'{OP_SEND, 0, 0, 0, 0, 0, 0, 1}, ONE_RESULT, ACT_REFUSED, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_CONFIG, 0, 0, 1, 0, 1}, ONE_RESULT, ACT_DATA, 1, 0},
            '{'{OP_SETUP, RT_CLASS_IN, HID_GET_IDLE, 0, 0, 1, 0, 1}, ONE_RESULT, ACT_DATA, 1,
              64'd125},
            '{'{OP_SOF, 0, 0, 0, 0, 0, 0, 1}, NO_RESULT, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_CLASS_OUT, REQ_SET_CONFIG, 0, 0, 0, 0, 1}, NO_RESULT, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_STD_OUT, REQ_SET_CONFIG, 1, 0, 0, 0, 1}, ONE_RESULT, ACT_ACK, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_CONFIG, 0, 0, 1, 0, 1}, ONE_RESULT, ACT_DATA, 1, 1},
            '{'{OP_SETUP, RT_STD_OUT, REQ_GET_CONFIG, 0, 0, 1, 0, 1}, NO_RESULT, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 0, 0, 0, 1}, ONE_RESULT,
              ACT_ACK, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_STATUS, 0, 0, 2, 0, 1}, ONE_RESULT, ACT_DATA, 2, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 0, 16'hFFFF, 0, 1},
              FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 0, 16'hFFFF, 0, 1},
              FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_HID, 8'h00}, 0, 0, 0, 1},
              NO_RESULT, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 0, 0, 0, 1},
              FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_REPORT, 8'h00}, 0, 40, 0, 1},
              FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_UNKNOWN, 8'h00}, 0, 64, 0, 1},
              ONE_RESULT, ACT_STALL, 0, 0},
            '{'{OP_SETUP, RT_CLASS_IN, HID_GET_REPORT, 0, 0, 8, 48'hFFFF_FFFF_FFFF, 1},
              ONE_RESULT, ACT_DATA, 8, 64'hFFFF_FFFF_FFFF_0000},
            '{'{OP_SETUP, RT_CLASS_IN, HID_GET_IDLE, 0, 16'hFFFF, 1, 0, 1}, ONE_RESULT,
              ACT_STALL, 0, 0},
            '{'{OP_SETUP, RT_ANY, REQ_UNKNOWN, 16'hFFFF, 0, 16'hFFFF, 0, 1}, ONE_RESULT,
              ACT_STALL, 0, 0},
            '{'{OP_SETUP, RT_CLASS_OUT, HID_SET_IDLE, 1, 0, 0, 0, 1}, ONE_RESULT, ACT_ACK, 0, 0},
            '{'{OP_SETUP, RT_CLASS_OUT, HID_SET_PROTOCOL, 16'hFF00, 0, 0, 0, 1}, ONE_RESULT,
              ACT_ACK, 0, 0},
            '{'{OP_SETUP, RT_CLASS_IN, HID_GET_PROTOCOL, 0, 0, 1, 0, 1}, ONE_RESULT, ACT_DATA,
              1, 64'hFF},
            '{'{OP_SOF, 0, 0, 0, 0, 0, 48'h0102_0304_0506, 1}, FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SOF, 0, 0, 0, 0, 0, 48'h0708_090A_0B0C, 1}, FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SOF, 0, 0, 0, 0, 0, 48'h1122_3344_5566, 1}, FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SOF, 0, 0, 0, 0, 0, 48'hA5A5_5A5A_C3C3, 1}, FROM_MODEL, ACT_NONE, 0, 0},
            '{'{OP_SEND, 0, 0, 0, 0, 0, 48'h0000_0000_0004, 0}, ONE_RESULT, ACT_REFUSED, 0, 0},
            '{'{OP_SEND, 0, 0, 0, 0, 0, 0, 1}, ONE_RESULT, ACT_REPORT, 8, 0},
            '{'{OP_RESET, 0, 0, 0, 0, 0, 0, 1}, NO_RESULT, ACT_NONE, 0, 0},
            '{'{OP_SEND, 0, 0, 0, 0, 0, 0, 1}, ONE_RESULT, ACT_REFUSED, 0, 0}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            typed = '{directed[i].action, SRC_INLINE, 8'd0, directed[i].count,
                      directed[i].data, 1'b1};
            send_transfer(directed[i].xfer, directed[i].kind, typed);
        end
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_lengths(10'd0, 10'd0, 10'd0, 10'd0);
                1: write_lengths(10'd255, 10'd1020, 10'd255, 10'd255);
                2: write_lengths(10'd64, 10'd224, 10'd32, 10'd96);
                default: write_lengths(10'($urandom_range(0, 255)),
                                       ($urandom_range(0, 2) == 0)
                                           ? 10'(PACKET_BYTES * $urandom_range(0, 31))
                                           : 10'($urandom_range(0, 1020)),
                                       10'($urandom_range(0, 255)),
                                       10'($urandom_range(0, 255)));
            endcase
            burst_mode = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) send_transfer(random_request(), FROM_MODEL, '0);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/uhid_pkg.sv
rtl/uhid_ctrl.sv
rtl/uhid_dp.sv
rtl/usb_hid_control_request_handler.sv
test/tb.sv
